// File: rtl/core/rsb_pkg.sv
// Shared types and constants of the run-length sprite blitter.
package rsb_pkg;

  localparam int FRAME_WIDTH_DEF  = 512;
  localparam int FRAME_HEIGHT_DEF = 512;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 17;
  localparam int PIX_W   = 4;
  localparam int DIM_W   = 16;
  localparam int ORG_W   = 9;
  localparam int PAL_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W = 3;
  localparam int RUN_W   = 5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd2;

  // Header phases
  localparam logic [PHASE_W-1:0] PHASE_WIDTH_HI  = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_WIDTH_LO  = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_HEIGHT_HI = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_HEIGHT_LO = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_RUNS      = 3'd4;

  // Palette values below this are transparent
  localparam logic [PIX_W-1:0] COLOR_MIN = 4'd5;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;   // latch the accepted request byte
    logic calc_base;   // compute row base and column for the run
    logic step;        // walk one pixel
    logic emit_rej;    // post the rejected status
    logic emit_fin;    // post the finished status and rearm the header
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_last;    // next byte closes the header
    logic runs;        // next byte is a run
    logic rej_now;     // image being closed exceeds the frame
    logic empty_now;   // image being closed has no pixels
    logic empty;       // stored image has no pixels
    logic emit_en;     // current run writes pixels
    logic row_end;     // this step walks the image's last pixel
    logic rem_zero;    // this step walks the run's last pixel
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

// File: rtl/core/rsb_if.sv
// Request and result channel interfaces of the sprite blitter.
interface rsb_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsb_pkg::BYTE_W-1:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink   (input valid, input image_byte, output ready);
endinterface

interface rsb_out_if;
  logic                      valid;
  logic                      ready;
  logic [rsb_pkg::KIND_W-1:0] kind;
  logic [rsb_pkg::ADDR_W-1:0] byte_address;
  logic                      high_half;
  logic [rsb_pkg::PIX_W-1:0]  pixel_value;
  logic                      last;

  modport source (output valid, output kind, output byte_address, output high_half,
                  output pixel_value, output last, input ready);
  modport sink   (input valid, input kind, input byte_address, input high_half,
                  input pixel_value, input last, output ready);
endinterface

// File: rtl/core/rle_sprite_blit_4bpp.sv
// Top level of the run-length sprite blitter for a 4-bit packed framebuffer.
// Header bytes are accepted one at a time; after the fourth, a rejected image posts reject
// (then finish if empty) and an empty one posts finish. A run byte (1 to 32 pixels) is
// accepted, its row base multiplied, then one pixel walked per cycle; the closing run posts finish.
// Writes land in the output register as the walker steps; a full register holds the walker.
// Reset is synchronous, active low: clears config, phase, state and result valid; awaits a header.
module rle_sprite_blit_4bpp #(
  parameter int FRAME_WIDTH  = rsb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rsb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsb_pkg::PAL_W-1:0]     cfg_wdata,
  rsb_in_if.sink                        in_ch,
  rsb_out_if.source                     out_ch
);

  // Command and status between the sequencer and the datapath
  rsb_pkg::cmd_t cmd;
  rsb_pkg::sts_t sts;

  // Sequencer: takes one request at a time, walks its pixels, posts status
  // results. Stall the walker only when a write pixel meets a full result
  // register; transparent pixels advance one per cycle regardless.
  rsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config registers, header capture, bounds check, row base and
  // column walker, and the output register that decouples the result side.
  rsb_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_ch.image_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/core/rsb_dp.sv
// Datapath of the sprite blitter: config, header, pixel walker, result register.
module rsb_dp #(
  parameter int FRAME_WIDTH  = rsb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rsb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsb_pkg::PAL_W-1:0]     cfg_wdata,
  input  logic [rsb_pkg::BYTE_W-1:0]    in_byte,
  input  rsb_pkg::cmd_t                 cmd,
  output rsb_pkg::sts_t                 sts,
  rsb_out_if.source                     out_ch
);

  localparam int FW_W   = $clog2(FRAME_WIDTH + 1);
  localparam int ROW_W  = rsb_pkg::ADDR_W;
  localparam int RB_W   = rsb_pkg::ADDR_W + 1;
  localparam int PROD_W = ROW_W + FW_W;
  localparam logic [FW_W-1:0]   FW_V    = FW_W'(FRAME_WIDTH);
  localparam logic [RB_W-1:0]   FW_STEP = RB_W'(FRAME_WIDTH);
  localparam logic [ROW_W-1:0]  FW_LIM  = ROW_W'(FRAME_WIDTH);
  localparam logic [ROW_W-1:0]  FH_LIM  = ROW_W'(FRAME_HEIGHT);

  localparam int DW = rsb_pkg::DIM_W;

  logic [rsb_pkg::PAL_W-1:0]   palette_r;
  logic [rsb_pkg::ORG_W-1:0]   origin_x_r, origin_y_r;
  logic [rsb_pkg::PHASE_W-1:0] phase_r;
  logic [DW-1:0]               width_r, height_r;
  logic [DW-1:0]               col_cnt_r, row_cnt_r;
  logic                        rejected_r;
  logic [rsb_pkg::BYTE_W-1:0]  run_byte_r;
  logic [rsb_pkg::RUN_W-1:0]   rem_r;
  logic [RB_W-1:0]             rb_r;
  logic [ROW_W-1:0]            col_r;

  logic                        out_valid_r;
  logic [rsb_pkg::KIND_W-1:0]  kind_r;
  logic [rsb_pkg::ADDR_W-1:0]  addr_r;
  logic                        high_r;
  logic [rsb_pkg::PIX_W-1:0]   pix_r;
  logic                        last_r;

  logic [DW-1:0]               height_full;
  logic [ROW_W-1:0]            row_abs;
  logic [PROD_W-1:0]           prod;
  logic [rsb_pkg::PIX_W-1:0]   color;
  logic                        emit_en;
  logic                        col_end;
  logic                        row_end;
  logic                        rem_zero;
  logic                        empty;
  logic                        out_load;
  logic [rsb_pkg::ADDR_W-1:0]  pix_addr;

  assign height_full = {height_r[DW-1:8], in_byte};
  assign row_abs     = ROW_W'(origin_y_r) + ROW_W'(row_cnt_r);
  assign prod        = row_abs * FW_V;
  assign color       = palette_r[{run_byte_r[2:0], 2'b00} +: rsb_pkg::PIX_W];
  assign emit_en     = !rejected_r && (color >= rsb_pkg::COLOR_MIN);
  assign col_end     = ({1'b0, col_cnt_r} + 17'd1) == {1'b0, width_r};
  assign row_end     = col_end && (({1'b0, row_cnt_r} + 17'd1) == {1'b0, height_r});
  assign rem_zero    = (rem_r == '0);
  assign empty       = (width_r == '0) || (height_r == '0);
  assign pix_addr    = rb_r[RB_W-1:1] + {1'b0, col_r[ROW_W-1:1]};
  assign out_load    = cmd.emit_fin || cmd.emit_rej || (cmd.step && emit_en);

  always_comb begin
    sts.hdr_last  = (phase_r == rsb_pkg::PHASE_HEIGHT_LO);
    sts.runs      = (phase_r == rsb_pkg::PHASE_RUNS);
    sts.rej_now   = ((ROW_W'(origin_x_r) + ROW_W'(width_r)) > FW_LIM) ||
                    ((ROW_W'(origin_y_r) + ROW_W'(height_full)) > FH_LIM);
    sts.empty_now = (width_r == '0) || (height_full == '0);
    sts.empty     = empty;
    sts.emit_en   = emit_en;
    sts.row_end   = row_end;
    sts.rem_zero  = rem_zero;
    sts.out_free  = !out_valid_r || out_ch.ready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r  <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsb_pkg::CFG_PALETTE:  palette_r  <= cfg_wdata;
        rsb_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_wdata[rsb_pkg::ORG_W-1:0];
        rsb_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_wdata[rsb_pkg::ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // Header phase and reject flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rsb_pkg::PHASE_WIDTH_HI;
      rejected_r <= 1'b0;
    end else if (cmd.emit_fin) begin
      phase_r    <= rsb_pkg::PHASE_WIDTH_HI;
      rejected_r <= 1'b0;
    end else if (cmd.take_byte && phase_r != rsb_pkg::PHASE_RUNS) begin
      phase_r <= phase_r + 3'd1;
      if (phase_r == rsb_pkg::PHASE_HEIGHT_LO) begin
        rejected_r <= sts.rej_now;
      end
    end
  end

  // Image geometry, walker position and run latch
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      case (phase_r)
        rsb_pkg::PHASE_WIDTH_HI:  width_r[DW-1:8]  <= in_byte;
        rsb_pkg::PHASE_WIDTH_LO:  width_r[7:0]     <= in_byte;
        rsb_pkg::PHASE_HEIGHT_HI: height_r[DW-1:8] <= in_byte;
        rsb_pkg::PHASE_HEIGHT_LO: begin
          height_r[7:0] <= in_byte;
          col_cnt_r     <= '0;
          row_cnt_r     <= '0;
        end
        default: run_byte_r <= in_byte;
      endcase
    end else if (cmd.emit_fin) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.calc_base) begin
      rb_r  <= prod[RB_W-1:0];
      col_r <= ROW_W'(origin_x_r) + ROW_W'(col_cnt_r);
      rem_r <= run_byte_r[rsb_pkg::BYTE_W-1:3];
    end else if (cmd.step) begin
      rem_r <= rem_r - 5'd1;
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_cnt_r + 16'd1;
        rb_r      <= rb_r + FW_STEP;
        col_r     <= ROW_W'(origin_x_r);
      end else begin
        col_cnt_r <= col_cnt_r + 16'd1;
        col_r     <= col_r + 17'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.emit_fin) begin
        kind_r <= rsb_pkg::KIND_FINISH;
        addr_r <= '0;
        high_r <= 1'b0;
        pix_r  <= '0;
        last_r <= 1'b1;
      end else if (cmd.emit_rej) begin
        kind_r <= rsb_pkg::KIND_REJECT;
        addr_r <= '0;
        high_r <= 1'b0;
        pix_r  <= '0;
        last_r <= !empty;
      end else begin
        kind_r <= rsb_pkg::KIND_PIXEL;
        addr_r <= pix_addr;
        high_r <= ~col_r[0];
        pix_r  <= color;
        last_r <= rem_zero && !row_end;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.byte_address = addr_r;
  assign out_ch.high_half    = high_r;
  assign out_ch.pixel_value  = pix_r;
  assign out_ch.last         = last_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result posted over a pending result");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= rsb_pkg::PHASE_RUNS)
    else $error("header phase out of range");
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rsb_pkg::PHASE_RUNS && width_r != '0) |-> (col_cnt_r < width_r))
    else $error("walker column beyond image width");
  a_fin_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_fin |=> (phase_r == rsb_pkg::PHASE_WIDTH_HI && !rejected_r))
    else $error("finish did not rearm header");
`endif

endmodule

// File: rtl/core/rsb_ctrl.sv
// Controller state machine of the sprite blitter.
module rsb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsb_pkg::sts_t sts,
  output rsb_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_RUN  = 5'b00100,
    S_REJ  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   go;

  assign in_ready = (state_r == S_IDLE);
  assign go       = !sts.emit_en || sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (sts.runs) begin
            state_nxt = S_LOAD;
          end else if (sts.hdr_last) begin
            if (sts.rej_now) begin
              state_nxt = S_REJ;
            end else if (sts.empty_now) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_LOAD: begin
        cmd.calc_base = 1'b1;
        state_nxt     = S_RUN;
      end
      S_RUN: begin
        if (go) begin
          cmd.step = 1'b1;
          if (sts.row_end) begin
            state_nxt = S_FIN;
          end else if (sts.rem_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REJ: begin
        if (sts.out_free) begin
          cmd.emit_rej = 1'b1;
          state_nxt    = sts.empty ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
